FILE: hw/rtl/cbst_pkg.sv
// shared types and constants for the complete bst level-order block
package cbst_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int KEY_BITS_DEF = 16;
    localparam int POS_BITS     = 6;

    // per-cycle commands broadcast along the cell row
    typedef struct packed {
        logic ins;    // insert the word on the key bus
        logic shift;  // move every entry one cell toward cell 0
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

endpackage

FILE: hw/rtl/cbst_cell.sv
// one insertion-sort cell: holds one key and its occupied bit
module cbst_cell
    import cbst_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_ctl_t                  ctl,
    input  logic signed [KEY_BITS-1:0] key_bus,
    input  logic                       left_occ,
    input  logic                       left_gt,
    input  logic signed [KEY_BITS-1:0] left_key,
    input  logic                       right_occ,
    input  logic signed [KEY_BITS-1:0] right_key,
    output logic                       occ,
    output logic                       gt,
    output logic signed [KEY_BITS-1:0] key
);

    logic                       occ_reg;
    logic                       occ_next;
    logic signed [KEY_BITS-1:0] key_reg;
    logic signed [KEY_BITS-1:0] key_next;
    logic                       take;

    // strictly greater, so equal keys stay ahead of the new one
    assign gt   = occ_reg && (key_reg > key_bus);
    assign take = ctl.ins && (gt || (!occ_reg && left_occ));

    always_comb
    begin
        occ_next = occ_reg;
        key_next = key_reg;
        if (ctl.shift)
        begin
            occ_next = right_occ;
            key_next = right_key;
        end
        else if (take)
        begin
            occ_next = 1'b1;
            key_next = left_gt ? left_key : key_bus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign occ = occ_reg;
    assign key = key_reg;

endmodule

FILE: hw/rtl/cbst_walk.sv
// in-order walker over the heap numbering of a complete tree
module cbst_walk
    import cbst_pkg::*;
#(
    parameter int CNT_W = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             step,
    input  logic [CNT_W-1:0] n_in,
    output logic [CNT_W-1:0] node
);

    localparam int W = CNT_W + 1;

    logic [CNT_W-1:0] node_reg;
    logic [CNT_W-1:0] node_next;

    // descend to the leftmost node under m
    function automatic logic [W-1:0] leftmost(input logic [W-1:0] m, input logic [W-1:0] n);
        logic [W-1:0] v;
        v = m;
        for (int s = 0; s < CNT_W; s++)
        begin
            if ({v[W-2:0], 1'b0} <= n && !v[W-1])
                v = {v[W-2:0], 1'b0};
        end
        return v;
    endfunction

    // climb past right-child links, then one more level
    function automatic logic [W-1:0] climb(input logic [W-1:0] m);
        logic [W-1:0] v;
        logic         done;
        v    = m;
        done = 1'b0;
        for (int s = 0; s < CNT_W; s++)
        begin
            if (!done)
            begin
                done = !v[0];
                v    = v >> 1;
            end
        end
        return v;
    endfunction

    logic [W-1:0] n_w;
    logic [W-1:0] cur_w;
    logic [W-1:0] right_w;
    logic [W-1:0] succ_w;
    logic [W-1:0] first_w;

    assign n_w     = W'(n_in);
    assign cur_w   = W'(node_reg);
    assign right_w = {cur_w[W-2:0], 1'b1};
    assign first_w = leftmost(W'(1), n_w);

    always_comb
    begin
        if (!cur_w[W-1] && right_w <= n_w)
            succ_w = leftmost(right_w, n_w);
        else
            succ_w = climb(cur_w);
    end

    always_comb
    begin
        node_next = node_reg;
        if (start)
            node_next = first_w[CNT_W-1:0];
        else if (step)
            node_next = succ_w[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_reg <= CNT_W'(1);
        else
            node_reg <= node_next;
    end

    assign node = node_reg;

endmodule

FILE: hw/rtl/complete_bst_level_order.sv
// top level: sorting cell row, in-order placement into a buffer, level-order emission
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_ready  | key_in, last_in
//  out     | output    | out_valid / out_ready| key_out, tree_position, last_out, overflow
//
// loading accepts one input word per cycle; the cell row keeps the keys sorted as they arrive
// after the word marked last, the row shifts out key by key while the in-order walker
// places each key at its heap slot in the buffer; the output words then follow, each
// read through the buffer read port into a register and then into the output word
// register, with no new read while one is in flight; after the closing word the block
// stays busy until the final word of the set is taken, and in_ready is low meanwhile
// reset clears the cell occupied bits, the key count and the dropped flag; no clearing pass
// a stalled output word holds its register; reads are issued only into a free slot
module complete_bst_level_order
    import cbst_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [KEY_BITS-1:0] key_in,
    input  logic                       last_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [KEY_BITS-1:0] key_out,
    output logic [POS_BITS-1:0]        tree_position,
    output logic                       last_out,
    output logic                       overflow
);

    localparam int CNT_W = $clog2(MAX_KEYS + 1);
    localparam int AW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    // control state
    state_t           st_reg;
    state_t           st_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] n_next;
    logic [CNT_W-1:0] drain_cnt_reg;
    logic [CNT_W-1:0] drain_cnt_next;
    logic [CNT_W-1:0] issue_reg;
    logic [CNT_W-1:0] issue_next;
    logic             rd_pend_reg;
    logic [CNT_W-1:0] rd_pos_reg;

    // output word register
    logic                       out_valid_reg;
    logic signed [KEY_BITS-1:0] out_key_reg;
    logic [POS_BITS-1:0]        out_pos_reg;
    logic                       out_last_reg;
    logic                       out_ovf_reg;

    logic in_fire;
    logic out_fire;
    logic store_key;
    logic rd_en;
    logic drain_en;
    logic walk_start;

    cell_ctl_t ctl;

    // cell row
    logic                       cell_occ [MAX_KEYS];
    logic                       cell_gt  [MAX_KEYS];
    logic signed [KEY_BITS-1:0] cell_key [MAX_KEYS];

    // placement buffer, indexed by heap slot and written in in-order walk order during the drain
    logic signed [KEY_BITS-1:0] mem [MAX_KEYS];
    logic signed [KEY_BITS-1:0] rd_data_reg;

    logic [CNT_W-1:0] walk_n;
    logic [CNT_W-1:0] node;
    logic [CNT_W-1:0] wr_slot;

    assign in_ready  = (st_reg == ST_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign store_key = in_fire && (count_reg < CNT_W'(MAX_KEYS));
    assign drain_en  = (st_reg == ST_DRAIN);
    assign walk_start = in_fire && last_in;

    assign ctl.ins   = store_key;
    assign ctl.shift = drain_en;

    // a free output slot exists when nothing is waiting or the waiting word leaves now
    assign rd_en = (st_reg == ST_EMIT) && !rd_pend_reg && (issue_reg < n_reg)
                   && (!out_valid_reg || out_ready);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEYS; gi++)
        begin : g_cell
            logic                       l_occ;
            logic                       l_gt;
            logic signed [KEY_BITS-1:0] l_key;
            logic                       r_occ;
            logic signed [KEY_BITS-1:0] r_key;

            if (gi == 0)
            begin : g_head
                // cell 0 sees an occupied, not-greater neighbor on its left
                assign l_occ = 1'b1;
                assign l_gt  = 1'b0;
                assign l_key = '0;
            end
            else
            begin : g_body
                assign l_occ = cell_occ[gi-1];
                assign l_gt  = cell_gt[gi-1];
                assign l_key = cell_key[gi-1];
            end

            if (gi == MAX_KEYS - 1)
            begin : g_tail
                assign r_occ = 1'b0;
                assign r_key = '0;
            end
            else
            begin : g_mid
                assign r_occ = cell_occ[gi+1];
                assign r_key = cell_key[gi+1];
            end

            cbst_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .key_bus   (key_in),
                .left_occ  (l_occ),
                .left_gt   (l_gt),
                .left_key  (l_key),
                .right_occ (r_occ),
                .right_key (r_key),
                .occ       (cell_occ[gi]),
                .gt        (cell_gt[gi]),
                .key       (cell_key[gi])
            );
        end
    endgenerate

    // walker starts with the set size of the closing word
    assign walk_n = (st_reg == ST_LOAD) ? count_next : n_reg;

    cbst_walk #(
        .CNT_W (CNT_W)
    ) u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .start (walk_start),
        .step  (drain_en),
        .n_in  (walk_n),
        .node  (node)
    );

    assign wr_slot = node - CNT_W'(1);

    // buffer write: smallest remaining key goes to the next in-order node
    always_ff @(posedge clk)
    begin
        if (drain_en)
            mem[wr_slot[AW-1:0]] <= cell_key[0];
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[issue_reg[AW-1:0]];
    end

    // sequencer
    always_comb
    begin
        st_next        = st_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        n_next         = n_reg;
        drain_cnt_next = drain_cnt_reg;
        issue_next     = issue_reg;

        unique case (st_reg)
            ST_LOAD:
            begin
                if (store_key)
                    count_next = count_reg + CNT_W'(1);
                else if (in_fire)
                    dropped_next = 1'b1;
                if (walk_start)
                begin
                    n_next         = count_next;
                    drain_cnt_next = '0;
                    st_next        = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_cnt_next = drain_cnt_reg + CNT_W'(1);
                if (drain_cnt_reg == n_reg - CNT_W'(1))
                begin
                    issue_next = '0;
                    st_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (rd_en)
                    issue_next = issue_reg + CNT_W'(1);
                if (out_fire && out_last_reg)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    st_next      = ST_LOAD;
                end
            end
            default:
            begin
                st_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            n_reg         <= '0;
            drain_cnt_reg <= '0;
            issue_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            n_reg         <= n_next;
            drain_cnt_reg <= drain_cnt_next;
            issue_reg     <= issue_next;
            rd_pend_reg   <= rd_en;
            if (rd_pend_reg)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_pos_reg <= issue_reg;
        if (rd_pend_reg)
        begin
            out_key_reg  <= rd_data_reg;
            out_pos_reg  <= POS_BITS'(rd_pos_reg);
            out_last_reg <= (rd_pos_reg == n_reg - CNT_W'(1));
            out_ovf_reg  <= dropped_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign key_out       = out_key_reg;
    assign tree_position = out_pos_reg;
    assign last_out      = out_last_reg;
    assign overflow      = out_ovf_reg;

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid_reg))
        else $error("input taken while an output word is pending");

    // the walker stays inside the tree while placing keys
    a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DRAIN) |-> (node != '0) && (node <= n_reg))
        else $error("walker left the tree during drain");

    // every set has at least one key
    a_set_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_LOAD) |-> (n_reg != '0))
        else $error("empty set closed");

    // the final word of a set hands control back to loading
    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && out_last_reg) |=> in_ready)
        else $error("block did not return to loading after final word");

endmodule

FILE: tb/testbench.sv
// testbench for the complete bst level-order block: directed sets, full store, random sets
`timescale 1ns / 1ps

module testbench;
    import cbst_pkg::*;

    typedef logic signed [KEY_BITS_DEF-1:0] key_t;

    // one node of the emitted tree, as the output channel carries it
    typedef struct {
        key_t                key;
        logic [POS_BITS-1:0] pos;
        logic                last;
        logic                ovf;
    } tree_node_t;

    // longest stretch with no handshake on either channel before the run is declared hung
    localparam int HANG_LIMIT   = 4000;
    localparam int SETTLE_TICKS = 20;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    key_t                key_in;
    logic                last_in;
    logic                out_valid;
    logic                out_ready;
    key_t                key_out;
    logic [POS_BITS-1:0] tree_position;
    logic                last_out;
    logic                overflow;

    // idling percentages, changed between phases
    int send_idle_pct;
    int recv_stall_pct;

    // predictor state: the keys of the open set in ascending order, and the drop flag
    key_t       set_keys_sorted[$];
    logic       set_dropped;
    // tree nodes still owed by the block, oldest first
    tree_node_t pending_nodes[$];

    int mismatch_count;
    int idle_cycles;

    complete_bst_level_order DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .key_in        (key_in),
        .last_in       (last_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .key_out       (key_out),
        .tree_position (tree_position),
        .last_out      (last_out),
        .overflow      (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // lay the sorted keys into heap slots by an in-order walk of the complete
    // tree of n nodes (heap numbering from 1), then queue them in slot order
    task automatic emit_tree_nodes();
        key_t       slot_key[MAX_KEYS_DEF];
        int         walk_stack[MAX_KEYS_DEF];
        int         sp;
        int         node;
        int         rank;
        int         n;
        tree_node_t tn;
        n    = set_keys_sorted.size();
        sp   = 0;
        node = 1;
        rank = 0;
        while (node <= n || sp > 0)
        begin
            // go as far left as the tree allows
            while (node <= n)
            begin
                walk_stack[sp] = node;
                sp++;
                node = 2 * node;
            end
            sp--;
            node = walk_stack[sp];
            slot_key[node - 1] = set_keys_sorted[rank];
            rank++;
            node = 2 * node + 1;
        end
        for (int i = 0; i < n; i++)
        begin
            tn.key  = slot_key[i];
            tn.pos  = i[POS_BITS-1:0];
            tn.last = (i == n - 1);
            tn.ovf  = set_dropped;
            pending_nodes.push_back(tn);
        end
        set_keys_sorted.delete();
        set_dropped = 1'b0;
    endtask

    // one accepted word: insert behind equal keys, or drop when the store is full
    task automatic load_key(input key_t k, input logic closes_set);
        int idx;
        if (set_keys_sorted.size() < MAX_KEYS_DEF)
        begin
            idx = set_keys_sorted.size();
            while (idx > 0 && set_keys_sorted[idx - 1] > k)
                idx--;
            set_keys_sorted.insert(idx, k);
        end
        else
        begin
            set_dropped = 1'b1;
        end
        if (closes_set)
            emit_tree_nodes();
    endtask

    // ------------------------------------------------------------------
    // sender: one word per call, valid held until the handshake
    // ------------------------------------------------------------------

    // called at a rising edge; valid is only lowered when a gap is taken, so
    // back-to-back words never see valid dropped and raised in one step
    task automatic send_key(input key_t k, input logic closes_set);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        key_in   <= k;
        last_in  <= closes_set;
        @(posedge clk);
        // in_ready read here is the value seen by this edge
        while (!in_ready)
            @(posedge clk);
        load_key(k, closes_set);
    endtask

    // mostly full-range keys, with extremes and a narrow band that forces duplicates
    function automatic key_t pick_key();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
            return $urandom_range(0, 1) ? key_t'(16'sh7fff) : key_t'(16'sh8000);
        else if (mode <= 2)
            return key_t'(int'($urandom_range(0, 6)) - 3);
        else
            return key_t'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // sample at the edge first (pre-edge values), then pick the next ready
    always @(posedge clk)
    begin
        tree_node_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_nodes.size() == 0)
            begin
                report_mismatch("word with no node owed, position", int'(tree_position), -1);
            end
            else
            begin
                want = pending_nodes.pop_front();
                if (key_out !== want.key)
                    report_mismatch($sformatf("key_out at position %0d", want.pos),
                                    int'(key_out), int'(want.key));
                if (tree_position !== want.pos)
                    report_mismatch("tree_position", int'(tree_position), int'(want.pos));
                if (last_out !== want.last)
                    report_mismatch($sformatf("last_out at position %0d", want.pos),
                                    int'(last_out), int'(want.last));
                if (overflow !== want.ovf)
                    report_mismatch($sformatf("overflow at position %0d", want.pos),
                                    int'(overflow), int'(want.ovf));
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // hang detection: cycles in which neither channel completes a word
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", HANG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // one-key sets at both extremes and at zero: the root is the whole tree
    task automatic test_single_keys();
        send_key(key_t'(16'sh8000), 1'b1);
        send_key(key_t'(16'sh7fff), 1'b1);
        send_key(key_t'(0), 1'b1);
    endtask

    // extremes, neighbors of zero and repeated keys; equal keys keep arrival order
    task automatic test_extremes_and_duplicates();
        key_t mixed[9];
        mixed = '{key_t'(16'sh7fff), key_t'(16'sh8000), key_t'(0), key_t'(-1), key_t'(1),
                  key_t'(0), key_t'(16'sh7fff), key_t'(16'sh8000), key_t'(5)};
        foreach (mixed[i])
            send_key(mixed[i], i == 8);
    endtask

    // seven descending keys fill a perfect tree of three levels
    task automatic test_perfect_tree();
        for (int i = 0; i < 7; i++)
            send_key(key_t'(300 - 100 * i), i == 6);
    endtask

    // store at capacity: exactly full, or extra words dropped with the last one dropped too
    task automatic test_store_full(input int set_size);
        for (int i = 0; i < set_size; i++)
            send_key(pick_key(), i == set_size - 1);
    endtask

    // random well-formed sets, mostly small, a few large or past capacity
    task automatic test_random_sets(input int item_budget);
        int sent;
        int n;
        int pick;
        sent = 0;
        while (sent < item_budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                n = $urandom_range(60, 68);
            else if (pick < 15)
                n = $urandom_range(11, 32);
            else
                n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
                send_key(pick_key(), i == n - 1);
            sent += n;
        end
    endtask

    initial
    begin
        // every input known from time zero
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        key_in         = '0;
        last_in        = 1'b0;
        out_ready      = 1'b0;
        send_idle_pct  = 26;
        recv_stall_pct = 72;
        mismatch_count = 0;
        idle_cycles    = 0;
        set_dropped    = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase one: sender idles now and then, receiver stalls most of the time
        test_single_keys();
        test_extremes_and_duplicates();
        test_perfect_tree();
        test_store_full(MAX_KEYS_DEF);
        test_random_sets(80);

        // phase two: sender mostly idle, receiver stalls occasionally
        send_idle_pct  = 72;
        recv_stall_pct = 26;
        test_store_full(MAX_KEYS_DEF + 3);
        test_random_sets(80);

        // phase three: full rate on both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_store_full(MAX_KEYS_DEF + 1);
        test_random_sets(80);

        in_valid <= 1'b0;
        // drain whatever the block still owes; the watchdog bounds this wait
        while (pending_nodes.size() != 0)
            @(posedge clk);
        // catch any stray word after the last node
        repeat (SETTLE_TICKS) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
